FILE: hw/rtl/wall_follow_stepper_drive_assert.svh
// Assertion macros for the wall-follow stepper drive.
// Used by the top level; expects clk and arst_n in scope.
`ifndef WALL_FOLLOW_STEPPER_DRIVE_ASSERT_SVH
`define WALL_FOLLOW_STEPPER_DRIVE_ASSERT_SVH

// check c in the same cycle as a
`define WFSD_ASSERT_SAME(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// check c in the cycle after a
`define WFSD_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: hw/rtl/wfsd_pkg.sv
// Shared types, constants and tables of the wall-follow stepper drive.
// No dependencies.
package wfsd_pkg;

	localparam int STEP_PHASES = 8;
	localparam int PHASE_W     = $clog2(STEP_PHASES);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(STEP_PHASES - 1);

	localparam logic [7:0] LEFT_COILS [STEP_PHASES] =
		'{8'h04, 8'h06, 8'h02, 8'h03, 8'h01, 8'h09, 8'h08, 8'h0C};
	localparam logic [7:0] RIGHT_COILS [STEP_PHASES] =
		'{8'hC0, 8'h80, 8'h90, 8'h10, 8'h30, 8'h20, 8'h60, 8'h40};

	localparam logic signed [15:0] COEF_A1 = 16'sd25575;
	localparam logic signed [15:0] COEF_A2 = -16'sd10508;
	localparam logic signed [15:0] COEF_B0 = 16'sd329;
	localparam logic signed [15:0] COEF_B1 = 16'sd658;

	localparam logic signed [15:0] STEER_LOW  = 16'sd30;
	localparam logic signed [15:0] STEER_HIGH = 16'sd45;

	localparam logic [4:0] PERIOD_FAST  = 5'd15;
	localparam logic [4:0] PERIOD_MID_A = 5'd17;
	localparam logic [4:0] PERIOD_MID_B = 5'd19;
	localparam logic [4:0] PERIOD_SLOW  = 5'd21;
	localparam logic [4:0] PERIOD_RESET = 5'd20;

	localparam logic [15:0] FILTER_PERIOD_RESET = 16'd500;
	localparam logic [15:0] RIGHT_PERIOD_RESET  = 16'd20;
	localparam logic [15:0] STOP_LEVEL_RESET    = 16'd80;

	typedef enum logic [1:0] {
		REG_FILTER_PERIOD = 2'd0,
		REG_RIGHT_PERIOD  = 2'd1,
		REG_STOP_LEVEL    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OPND_D1,
		OPND_D2,
		OPND_W
	} opnd_sel_t;

	typedef enum logic {
		CH_RIGHT,
		CH_LEFT
	} chan_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RW0,
		ST_RW1,
		ST_RY0,
		ST_RY1,
		ST_RY2,
		ST_LW0,
		ST_LW1,
		ST_LY0,
		ST_LY1,
		ST_LY2,
		ST_EVAL,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic              ready;
		logic              mac_en;
		logic              mac_load;
		logic              init_sample;
		logic signed [15:0] coef;
		opnd_sel_t         opnd;
		chan_t             chan;
		logic              cap_w;
		logic              cap_y;
		logic              eval;
		logic              out_load;
	} ctrl_t;

endpackage

FILE: hw/rtl/wfsd_mac.sv
// Shared multiply-accumulate unit: acc = (load ? init : acc) + coef * opnd.
// 32-bit wrapping accumulator. Depends on nothing beyond its ports.
module wfsd_mac (
	input  logic               clk,
	input  logic               en,
	input  logic               load,
	input  logic [31:0]        init,
	input  logic signed [15:0] coef,
	input  logic signed [15:0] opnd,
	output logic [31:0]        sum
);

	logic [31:0]        acc_q;
	logic [31:0]        base;
	logic signed [31:0] prod;

	assign base = load ? init : acc_q;
	assign prod = coef * opnd;
	assign sum  = base + $unsigned(prod);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= sum;
		end
	end

endmodule

FILE: hw/rtl/wfsd_ctrl.sv
// Sequencer: walks both biquad channels through the shared MAC when a filter update is
// due, then evaluates the drive and hands the result to the output register. Uses wfsd_pkg.
module wfsd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           filt_go,
	input  logic           out_free,
	output wfsd_pkg::ctrl_t ctrl
);

	wfsd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfsd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = filt_go ? wfsd_pkg::ST_RW0 : wfsd_pkg::ST_EVAL;
				end
			end
			wfsd_pkg::ST_RW0: state_d = wfsd_pkg::ST_RW1;
			wfsd_pkg::ST_RW1: state_d = wfsd_pkg::ST_RY0;
			wfsd_pkg::ST_RY0: state_d = wfsd_pkg::ST_RY1;
			wfsd_pkg::ST_RY1: state_d = wfsd_pkg::ST_RY2;
			wfsd_pkg::ST_RY2: state_d = wfsd_pkg::ST_LW0;
			wfsd_pkg::ST_LW0: state_d = wfsd_pkg::ST_LW1;
			wfsd_pkg::ST_LW1: state_d = wfsd_pkg::ST_LY0;
			wfsd_pkg::ST_LY0: state_d = wfsd_pkg::ST_LY1;
			wfsd_pkg::ST_LY1: state_d = wfsd_pkg::ST_LY2;
			wfsd_pkg::ST_LY2: state_d = wfsd_pkg::ST_EVAL;
			wfsd_pkg::ST_EVAL: state_d = wfsd_pkg::ST_HOLD;
			wfsd_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = wfsd_pkg::ST_IDLE;
				end
			end
			default: state_d = wfsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.opnd = wfsd_pkg::OPND_D1;
		ctrl.chan = wfsd_pkg::CH_RIGHT;
		unique case (state_q)
			wfsd_pkg::ST_IDLE: ctrl.ready = 1'b1;
			wfsd_pkg::ST_RW0, wfsd_pkg::ST_LW0: begin
				ctrl.mac_en      = 1'b1;
				ctrl.mac_load    = 1'b1;
				ctrl.init_sample = 1'b1;
				ctrl.coef        = wfsd_pkg::COEF_A1;
				ctrl.opnd        = wfsd_pkg::OPND_D1;
			end
			wfsd_pkg::ST_RW1, wfsd_pkg::ST_LW1: begin
				ctrl.mac_en = 1'b1;
				ctrl.coef   = wfsd_pkg::COEF_A2;
				ctrl.opnd   = wfsd_pkg::OPND_D2;
				ctrl.cap_w  = 1'b1;
			end
			wfsd_pkg::ST_RY0, wfsd_pkg::ST_LY0: begin
				ctrl.mac_en   = 1'b1;
				ctrl.mac_load = 1'b1;
				ctrl.coef     = wfsd_pkg::COEF_B0;
				ctrl.opnd     = wfsd_pkg::OPND_W;
			end
			wfsd_pkg::ST_RY1, wfsd_pkg::ST_LY1: begin
				ctrl.mac_en = 1'b1;
				ctrl.coef   = wfsd_pkg::COEF_B1;
				ctrl.opnd   = wfsd_pkg::OPND_D1;
			end
			wfsd_pkg::ST_RY2, wfsd_pkg::ST_LY2: begin
				ctrl.mac_en = 1'b1;
				ctrl.coef   = wfsd_pkg::COEF_B0;
				ctrl.opnd   = wfsd_pkg::OPND_D2;
				ctrl.cap_y  = 1'b1;
			end
			wfsd_pkg::ST_EVAL: ctrl.eval = 1'b1;
			wfsd_pkg::ST_HOLD: ctrl.out_load = out_free;
			default: ctrl.ready = 1'b0;
		endcase
		unique case (state_q)
			wfsd_pkg::ST_LW0, wfsd_pkg::ST_LW1, wfsd_pkg::ST_LY0,
			wfsd_pkg::ST_LY1, wfsd_pkg::ST_LY2: ctrl.chan = wfsd_pkg::CH_LEFT;
			default: ctrl.chan = wfsd_pkg::CH_RIGHT;
		endcase
	end

endmodule

FILE: hw/rtl/wfsd_drive.sv
// Motor drive: tick counters, halt test, steering and half-step coil latch.
// Updated once per request on eval. Uses wfsd_pkg.
module wfsd_drive (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               eval,
	input  logic signed [15:0] right_level,
	input  logic signed [15:0] left_level,
	input  logic signed [15:0] stop_level,
	input  logic [15:0]        right_period,
	output logic [7:0]         motor_port,
	output logic               halted
);

	logic [15:0] left_ticks_q, right_ticks_q;
	logic [wfsd_pkg::PHASE_W-1:0] left_phase_q, right_phase_q;
	logic [4:0]  left_period_q;
	logic        steer_dir_q;
	logic [7:0]  port_q;
	logic        halted_q;

	logic [15:0] lt_inc, rt_inc;
	logic [4:0]  lp_d;
	logic        sd_d;
	logic        halt_d;
	logic        lstep, rstep;
	logic [7:0]  port_d;

	always_comb begin
		lt_inc = (left_ticks_q == 16'hFFFF) ? left_ticks_q : left_ticks_q + 16'd1;
		rt_inc = (right_ticks_q == 16'hFFFF) ? right_ticks_q : right_ticks_q + 16'd1;
		halt_d = right_level > stop_level;
		lp_d   = left_period_q;
		sd_d   = steer_dir_q;
		priority if (left_level > wfsd_pkg::STEER_LOW && left_level < wfsd_pkg::STEER_HIGH) begin
			lp_d = steer_dir_q ? wfsd_pkg::PERIOD_MID_B : wfsd_pkg::PERIOD_MID_A;
		end else if (left_level >= wfsd_pkg::STEER_HIGH) begin
			lp_d = wfsd_pkg::PERIOD_FAST;
			sd_d = 1'b0;
		end else if (left_level < wfsd_pkg::STEER_LOW) begin
			lp_d = wfsd_pkg::PERIOD_SLOW;
			sd_d = 1'b1;
		end else begin
			lp_d = left_period_q;
		end
		lstep  = !halt_d && (lt_inc >= {11'd0, lp_d});
		rstep  = !halt_d && (rt_inc >= right_period);
		port_d = port_q;
		if (lstep) begin
			port_d[3:0] = wfsd_pkg::LEFT_COILS[left_phase_q][3:0];
		end
		if (rstep) begin
			port_d[7:4] = wfsd_pkg::RIGHT_COILS[right_phase_q][7:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_ticks_q  <= '0;
			right_ticks_q <= '0;
			left_phase_q  <= '0;
			right_phase_q <= '0;
			left_period_q <= wfsd_pkg::PERIOD_RESET;
			steer_dir_q   <= 1'b0;
			port_q        <= '0;
			halted_q      <= 1'b0;
		end else if (eval) begin
			left_ticks_q  <= lstep ? 16'd0 : lt_inc;
			right_ticks_q <= rstep ? 16'd0 : rt_inc;
			if (lstep) begin
				left_phase_q <= (left_phase_q == wfsd_pkg::PHASE_LAST) ? '0 :
					left_phase_q + 1'b1;
			end
			if (rstep) begin
				right_phase_q <= (right_phase_q == wfsd_pkg::PHASE_LAST) ? '0 :
					right_phase_q + 1'b1;
			end
			left_period_q <= lp_d;
			steer_dir_q   <= sd_d;
			port_q        <= port_d;
			halted_q      <= halt_d;
		end
	end

	assign motor_port = port_q;
	assign halted     = halted_q;

endmodule

FILE: hw/rtl/wall_follow_stepper_drive.sv
// Top level of the wall-follow stepper drive: config registers, biquad state,
// output register. Uses wfsd_pkg, wfsd_mac, wfsd_ctrl, wfsd_drive, the assert header.
//
// channel  | direction | handshake          | payload
// s_*      | in        | s_tvalid/s_tready  | tdata: right_sample, left_sample
// m_*      | out       | m_tvalid/m_tready  | tdata: motor_port, right/left_level; tuser: halted
// cfg_*    | in        | cfg_we             | cfg_addr, cfg_wdata
//
// A request that triggers a filter update goes through accept, ten steps of the shared
// multiply-accumulate unit, evaluate and hand-off; otherwise only accept, evaluate and hand-off.
// Reset is asynchronous and brings all filter and motor state to its reset values.
// A finished result waits in the output register; the next request is taken meanwhile.
// A new result waits in the hand-off step while the output register is still full.
module wall_follow_stepper_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // right_sample, left_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // motor_port, right_level, left_level
	output logic        m_tuser,   // halted
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	wfsd_pkg::ctrl_t ctrl;

	logic [15:0]        filter_period_q, right_period_q;
	logic signed [15:0] stop_level_q;
	logic [15:0]        filter_ticks_q, ft_inc;
	logic               filt_go;
	logic               s_accept;
	logic               out_free;
	logic [7:0]         right_sample_q, left_sample_q;
	logic signed [15:0] rd1_q, rd2_q, ld1_q, ld2_q, w_q;
	logic signed [15:0] right_filt_q, left_filt_q;
	logic signed [15:0] d1, d2, opnd;
	logic [7:0]         sample;
	logic [31:0]        init, sum;
	logic [7:0]         motor_port;
	logic               halted;
	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;
	logic               m_tuser_q;

	assign s_tready = ctrl.ready;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign ft_inc   = (filter_ticks_q == 16'hFFFF) ? filter_ticks_q : filter_ticks_q + 16'd1;
	assign filt_go  = ft_inc >= filter_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_period_q <= wfsd_pkg::FILTER_PERIOD_RESET;
			right_period_q  <= wfsd_pkg::RIGHT_PERIOD_RESET;
			stop_level_q    <= wfsd_pkg::STOP_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				wfsd_pkg::REG_FILTER_PERIOD: filter_period_q <= cfg_wdata;
				wfsd_pkg::REG_RIGHT_PERIOD:  right_period_q  <= cfg_wdata;
				wfsd_pkg::REG_STOP_LEVEL:    stop_level_q    <= cfg_wdata;
				default: stop_level_q <= stop_level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			right_sample_q <= s_tdata[7:0];
			left_sample_q  <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_ticks_q <= '0;
		end else if (s_accept) begin
			filter_ticks_q <= filt_go ? 16'd0 : ft_inc;
		end
	end

	wfsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.filt_go  (filt_go),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	always_comb begin
		if (ctrl.chan == wfsd_pkg::CH_LEFT) begin
			d1     = ld1_q;
			d2     = ld2_q;
			sample = left_sample_q;
		end else begin
			d1     = rd1_q;
			d2     = rd2_q;
			sample = right_sample_q;
		end
		unique case (ctrl.opnd)
			wfsd_pkg::OPND_D1: opnd = d1;
			wfsd_pkg::OPND_D2: opnd = d2;
			wfsd_pkg::OPND_W:  opnd = w_q;
			default:           opnd = d1;
		endcase
		init = ctrl.init_sample ? {10'd0, sample, 14'd0} : 32'd0;
	end

	wfsd_mac u_mac (
		.clk  (clk),
		.en   (ctrl.mac_en),
		.load (ctrl.mac_load),
		.init (init),
		.coef (ctrl.coef),
		.opnd (opnd),
		.sum  (sum)
	);

	always_ff @(posedge clk) begin
		if (ctrl.cap_w) begin
			w_q <= $signed(sum[29:14]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd1_q        <= '0;
			rd2_q        <= '0;
			ld1_q        <= '0;
			ld2_q        <= '0;
			right_filt_q <= '0;
			left_filt_q  <= '0;
		end else if (ctrl.cap_y) begin
			if (ctrl.chan == wfsd_pkg::CH_LEFT) begin
				left_filt_q <= $signed(sum[29:14]);
				ld2_q       <= ld1_q;
				ld1_q       <= w_q;
			end else begin
				right_filt_q <= $signed(sum[29:14]);
				rd2_q        <= rd1_q;
				rd1_q        <= w_q;
			end
		end
	end

	wfsd_drive u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.eval         (ctrl.eval),
		.right_level  (right_filt_q),
		.left_level   (left_filt_q),
		.stop_level   (stop_level_q),
		.right_period (right_period_q),
		.motor_port   (motor_port),
		.halted       (halted)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata_q <= {left_filt_q, right_filt_q, motor_port};
			m_tuser_q <= halted;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`include "wall_follow_stepper_drive_assert.svh"

	`WFSD_ASSERT_SAME(a_no_overwrite, ctrl.out_load, !m_tvalid || m_tready, "result overwritten")
	`WFSD_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "request taken while busy")
	`WFSD_ASSERT_NEXT(a_halt_holds_coils, ctrl.eval && (right_filt_q > stop_level_q),
		$stable(motor_port), "coils moved while halted")

endmodule

FILE: tb/wall_follow_stepper_drive_tb.sv
// Self-checking testbench for the wall-follow stepper drive: sensor ticks on the input
// stream, coil pattern, halt flag and filtered levels checked against a built-in predictor.
// Depends on wfsd_pkg and wall_follow_stepper_drive.
`timescale 1ns / 100ps

module wall_follow_stepper_drive_tb;

	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 2000;

	localparam int FB1 = 25575;
	localparam int FB2 = 10508;
	localparam int FF0 = 329;
	localparam int FF1 = 658;

	localparam logic signed [15:0] STEER_LO = 16'sd30;
	localparam logic signed [15:0] STEER_HI = 16'sd45;
	localparam logic [4:0] PER_FAST  = 5'd15;
	localparam logic [4:0] PER_MID_A = 5'd17;
	localparam logic [4:0] PER_MID_B = 5'd19;
	localparam logic [4:0] PER_SLOW  = 5'd21;

	localparam logic [3:0] LEFT_NIBBLE [8] =
		'{4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9, 4'h8, 4'hC};
	localparam logic [3:0] RIGHT_NIBBLE [8] =
		'{4'hC, 4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4};

	typedef struct packed {
		logic        halted;
		logic [15:0] left_level;
		logic [15:0] right_level;
		logic [7:0]  motor_port;
	} drive_out_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;   // right_sample, left_sample
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // motor_port, right_level, left_level
	logic        m_tuser;          // halted
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = '0;
	logic [15:0] cfg_wdata = '0;

	wall_follow_stepper_drive uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0]        filt_period = 16'd500;
	logic [15:0]        rmot_period = 16'd20;
	logic signed [15:0] stop_lvl    = 16'sd80;
	logic [15:0]        filt_ticks  = '0;
	logic [15:0]        lmot_ticks  = '0;
	logic [15:0]        rmot_ticks  = '0;
	logic [2:0]         lphase      = '0;
	logic [2:0]         rphase      = '0;
	logic [15:0]        rdly1 = '0, rdly2 = '0, ldly1 = '0, ldly2 = '0;
	logic signed [15:0] rlevel      = '0;
	logic signed [15:0] llevel      = '0;
	logic [4:0]         lper        = 5'd20;
	logic               steer_back  = 1'b0;
	logic [7:0]         coil_latch  = '0;

	logic [15:0] pending_ticks [$];
	drive_out_t  expected_q [$];
	int          ticks_queued = 0;
	int          ticks_taken  = 0;
	int          results_seen = 0;
	int          mismatches   = 0;
	int          stall_cycles = 0;
	logic        tick_taken   = 1'b0;
	logic        steady       = 1'b0;

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [15:0] biquad_q14(input logic [7:0] smp,
			input logic [15:0] d1, input logic [15:0] d2, output logic [15:0] w16);
		int sd1, sd2, sw, w, y;
		sd1 = $signed(d1);
		sd2 = $signed(d2);
		w = (int'(smp) << 14) + FB1 * sd1 - FB2 * sd2;
		w16 = w[29:14];
		sw = $signed(w16);
		y = FF0 * sw + FF1 * sd1 + FF0 * sd2;
		return y[29:14];
	endfunction

	function automatic drive_out_t step_drive(input logic [7:0] rs, input logic [7:0] ls);
		drive_out_t r;
		logic [15:0] w_new;
		filt_ticks = bump(filt_ticks);
		lmot_ticks = bump(lmot_ticks);
		rmot_ticks = bump(rmot_ticks);
		if (filt_ticks >= filt_period) begin
			filt_ticks = '0;
			rlevel = biquad_q14(rs, rdly1, rdly2, w_new);
			rdly2 = rdly1;
			rdly1 = w_new;
			llevel = biquad_q14(ls, ldly1, ldly2, w_new);
			ldly2 = ldly1;
			ldly1 = w_new;
		end
		r.halted = rlevel > stop_lvl;
		if (llevel > STEER_LO && llevel < STEER_HI) begin
			lper = steer_back ? PER_MID_B : PER_MID_A;
		end else if (llevel >= STEER_HI) begin
			lper = PER_FAST;
			steer_back = 1'b0;
		end else if (llevel < STEER_LO) begin
			lper = PER_SLOW;
			steer_back = 1'b1;
		end
		if (!r.halted) begin
			if (lmot_ticks >= lper) begin
				coil_latch[3:0] = LEFT_NIBBLE[lphase];
				lphase = lphase + 3'd1;
				lmot_ticks = '0;
			end
			if (rmot_ticks >= rmot_period) begin
				coil_latch[7:4] = RIGHT_NIBBLE[rphase];
				rphase = rphase + 3'd1;
				rmot_ticks = '0;
			end
		end
		r.motor_port = coil_latch;
		r.right_level = rlevel;
		r.left_level = llevel;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// request driver and result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || tick_taken) begin
			if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
				s_tdata <= pending_ticks.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && (steady || $urandom_range(99) >= 20);
	end

	// monitor
	always @(posedge clk) begin : monitor
		drive_out_t want, got;
		tick_taken <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			results_seen++;
			got = {m_tuser, m_tdata};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, got);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				report_field("motor_port", want.motor_port, got.motor_port);
				report_field("halted", want.halted, got.halted);
				report_field("right_level", want.right_level, got.right_level);
				report_field("left_level", want.left_level, got.left_level);
			end
		end
		if (s_tvalid && s_tready) begin
			ticks_taken++;
			expected_q.push_back(step_drive(s_tdata[7:0], s_tdata[15:8]));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("wall_follow_stepper_drive: mismatch");
			$finish;
		end
	end

	task automatic push_tick(input logic [7:0] rs, input logic [7:0] ls);
		pending_ticks.push_back({ls, rs});
		ticks_queued++;
	endtask

	function automatic logic [7:0] clamp_sample(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// runs of steady sensor readings with a little jitter, plus random noise
	task automatic make_traffic(input int n);
		int count, len, rt, lt;
		count = 0;
		while (count < n) begin
			if ($urandom_range(9) == 0) begin
				push_tick(8'($urandom_range(255)), 8'($urandom_range(255)));
				count++;
			end else begin
				len = $urandom_range(30, 5);
				rt = $urandom_range(1) ? int'($urandom_range(255))
					: int'(stop_lvl) + int'($urandom_range(40)) - 20;
				lt = $urandom_range(1) ? int'($urandom_range(60, 20)) : int'($urandom_range(255));
				repeat (len) begin
					push_tick(clamp_sample(rt + int'($urandom_range(4)) - 2),
						clamp_sample(lt + int'($urandom_range(4)) - 2));
				end
				count += len;
			end
		end
	endtask

	task automatic drain();
		wait (ticks_taken == ticks_queued && results_seen >= ticks_queued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input wfsd_pkg::reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		unique case (idx)
			wfsd_pkg::REG_FILTER_PERIOD: filt_period = val;
			wfsd_pkg::REG_RIGHT_PERIOD:  rmot_period = val;
			wfsd_pkg::REG_STOP_LEVEL:    stop_lvl = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_drive(input logic [15:0] fp, input logic [15:0] rp,
			input logic [15:0] sl);
		write_reg(wfsd_pkg::REG_FILTER_PERIOD, fp);
		write_reg(wfsd_pkg::REG_RIGHT_PERIOD, rp);
		write_reg(wfsd_pkg::REG_STOP_LEVEL, sl);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, then zero periods so the filter and the right motor act on every tick
		push_tick(8'h00, 8'hFF);
		push_tick(8'hFF, 8'h00);
		drain();
		set_drive(16'd0, 16'd0, 16'sd32767);
		push_tick(8'hFF, 8'hFF);
		push_tick(8'h00, 8'h00);
		push_tick(8'hAA, 8'h55);
		push_tick(8'h55, 8'hAA);
		push_tick(8'h01, 8'h80);
		push_tick(8'h80, 8'h01);
		for (int i = 0; i < 14; i++)
			push_tick(8'd100, (i < 7) ? 8'd30 : 8'd60);
		drain();

		set_drive(16'd1, 16'd1, 16'sd80);
		make_traffic(80);
		drain();

		steady = 1'b1;
		set_drive(16'd2, 16'd3, 16'sd0);
		make_traffic(80);
		drain();
		steady = 1'b0;

		set_drive(16'd3, 16'd20, 16'sd120);
		make_traffic(80);
		drain();

		set_drive(16'd1, 16'd65535, -16'sd32768);
		make_traffic(50);
		drain();

		set_drive(16'($urandom_range(4, 1)), 16'($urandom_range(25, 1)),
			16'($urandom_range(200, 20)));
		make_traffic(80);
		drain();

		set_drive(16'd4, 16'd7, 16'sd32767);
		make_traffic(50);
		drain();

		// hold the motors for a stretch, then release
		set_drive(16'd65535, 16'd65535, -16'sd32768);
		repeat (40) push_tick(8'($urandom_range(255)), 8'($urandom_range(255)));
		drain();
		write_reg(wfsd_pkg::REG_STOP_LEVEL, 16'sd32767);
		make_traffic(20);
		drain();

		if (expected_q.size() != 0) begin
			$display("%0t: %0d results expected but never seen", $time, expected_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("wall_follow_stepper_drive: match");
		end else begin
			$display("wall_follow_stepper_drive: mismatch");
		end
		$finish;
	end

endmodule
